/* hw/rtl/aob_pkg.sv */
package aob_pkg;

    localparam int AOB_NCH      = 3;   // colour channels red, green, blue
    localparam int AOB_NSTG     = 7;   // register stages from input to result
    localparam int AOB_NDIV     = 4;   // divider stages at the tail
    localparam int AOB_DIV_BITS = 2;   // quotient bits resolved per divider stage
    localparam int AOB_IDX_W    = 2;

    typedef enum logic [AOB_IDX_W-1:0] {
        CFG_SRC_RED,
        CFG_SRC_GREEN,
        CFG_SRC_BLUE,
        CFG_SRC_OPACITY
    } t_cfg_idx;

    // destination pixel plus the pass-through decision
    typedef struct packed {
        logic                      byp;
        logic [AOB_NCH-1:0][7:0]   ch;
        logic [7:0]                alpha;
    } t_pix;

    // divider state: divisor, alpha, and per-channel partial remainder and dividend/quotient byte
    typedef struct packed {
        logic [15:0]               n;
        logic [7:0]                alpha;
        logic [AOB_NCH-1:0][15:0]  rem;
        logic [AOB_NCH-1:0][7:0]   lq;
    } t_div;

endpackage

/* hw/rtl/aob_pix_if.sv */
interface aob_pix_if;
    logic       valid;
    logic       ready;
    logic       covered;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (
        output valid, covered, dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );
    modport sink (
        input  valid, covered, dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

/* hw/rtl/aob_res_if.sv */
interface aob_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

/* hw/rtl/aob_cfg_if.sv */
interface aob_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [aob_pkg::AOB_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hw/rtl/aob_div_step.sv */
module aob_div_step (
    input  logic          i_clk,
    input  logic          i_en,
    input  aob_pkg::t_div i_div,
    output aob_pkg::t_div o_div
);
    import aob_pkg::*;

    t_div        r_div;
    t_div        n_div;
    logic [16:0] w_x;
    logic        w_ge;

    // restoring division: bring in the next dividend bit, compare, subtract
    always_comb begin
        n_div = i_div;
        w_x   = '0;
        w_ge  = 1'b0;
        for (int c = 0; c < AOB_NCH; c++) begin
            for (int s = 0; s < AOB_DIV_BITS; s++) begin
                w_x  = {n_div.rem[c], n_div.lq[c][7]};
                w_ge = (w_x >= {1'b0, i_div.n});
                n_div.rem[c] = w_ge ? 16'(w_x - {1'b0, i_div.n}) : w_x[15:0];
                n_div.lq[c]  = {n_div.lq[c][6:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

/* hw/rtl/alpha_over_blend.sv */
// Porter-Duff "over" of a programmed source colour and opacity onto a stream of
// non-premultiplied RGBA pixels. One pixel is taken every clock when the output
// is not stalled; a stall holds the whole pipeline in place while bubbles ahead
// of it still close up. The seven stages are: weight multiply, per-channel
// products, numerator sum with the alpha divide-by-255, then four divider
// stages that each settle two bits of the 8-bit colour quotients. Uncovered
// pixels and zero opacity pass the destination through unchanged. Configuration
// writes are always accepted and take effect at once, so change them only while
// no pixel is in flight.
module alpha_over_blend (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aob_pix_if.sink    i_pix,
    aob_res_if.source  o_res,
    aob_cfg_if.sink    i_cfg
);
    import aob_pkg::*;

    logic [7:0]           r_src [AOB_NCH];
    logic [7:0]           r_opa;

    logic [AOB_NSTG:0]    w_rdy;
    logic [AOB_NSTG-1:0]  r_vld;
    logic [AOB_NSTG-1:0]  w_vin;
    t_pix                 r_pix [AOB_NSTG];
    t_pix                 w_pix_in;

    logic [15:0]          r_w1;
    logic [15:0]          r_w2;
    logic [7:0]           w_inv;
    logic [15:0]          r_n;
    logic [23:0]          r_cw [AOB_NCH];
    logic [23:0]          r_pw [AOB_NCH];
    logic [24:0]          w_num [AOB_NCH];
    logic [15:0]          w_asum;
    t_div                 r_div;
    t_div                 w_div [AOB_NDIV+1];

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < AOB_NCH; c++) begin
                r_src[c] <= '0;
            end
            r_opa <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_SRC_RED:     r_src[0] <= i_cfg.data;
                CFG_SRC_GREEN:   r_src[1] <= i_cfg.data;
                CFG_SRC_BLUE:    r_src[2] <= i_cfg.data;
                CFG_SRC_OPACITY: r_opa    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage handshake: a stage moves when empty or when the next one moves
    assign w_vin = {r_vld[AOB_NSTG-2:0], i_pix.valid};

    always_comb begin
        w_rdy[AOB_NSTG] = o_res.ready;
        for (int k = AOB_NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_pix.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < AOB_NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage 0: source weight 255*s and destination weight d*(255-s)
    assign w_inv = 8'd255 - r_opa;

    always_comb begin
        w_pix_in.byp   = !i_pix.covered || (r_opa == 8'd0);
        w_pix_in.ch[0] = i_pix.dst_red;
        w_pix_in.ch[1] = i_pix.dst_green;
        w_pix_in.ch[2] = i_pix.dst_blue;
        w_pix_in.alpha = i_pix.dst_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_w1     <= {r_opa, 8'h00} - {8'h00, r_opa};
            r_w2     <= 16'(i_pix.dst_alpha) * 16'(w_inv);
            r_pix[0] <= w_pix_in;
        end
    end

    // stage 1: coverage total and the weighted channel products
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_n <= r_w1 + r_w2;
            for (int c = 0; c < AOB_NCH; c++) begin
                r_cw[c] <= 24'(r_src[c]) * 24'(r_w1);
                r_pw[c] <= 24'(r_pix[0].ch[c]) * 24'(r_w2);
            end
            r_pix[1] <= r_pix[0];
        end
    end

    // stage 2: numerators, alpha = n/255, divider setup
    // n stays below 65535, so (n + 1 + n/256) / 256 is exact for n/255
    assign w_asum = r_n + 16'd1 + {8'h00, r_n[15:8]};

    always_comb begin
        for (int c = 0; c < AOB_NCH; c++) begin
            w_num[c] = 25'(r_cw[c]) + 25'(r_pw[c]);
        end
    end

    // the quotient is a weighted mean of two bytes, so numerator < 256*n and
    // the top part numerator/256 already lies below n
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_div.n     <= r_n;
            r_div.alpha <= w_asum[15:8];
            for (int c = 0; c < AOB_NCH; c++) begin
                r_div.rem[c] <= w_num[c][23:8];
                r_div.lq[c]  <= w_num[c][7:0];
            end
            r_pix[2] <= r_pix[1];
        end
    end

    // stages 3 to 6: divider, pixel fields ride alongside
    assign w_div[0] = r_div;

    for (genvar g = 0; g < AOB_NDIV; g++) begin : g_div
        aob_div_step u_step (
            .i_clk (i_clk),
            .i_en  (w_rdy[3+g]),
            .i_div (w_div[g]),
            .o_div (w_div[g+1])
        );
    end

    for (genvar g = 3; g < AOB_NSTG; g++) begin : g_pix
        always_ff @(posedge i_clk) begin
            if (w_rdy[g]) begin
                r_pix[g] <= r_pix[g-1];
            end
        end
    end

    // result
    assign o_res.valid     = r_vld[AOB_NSTG-1];
    assign o_res.out_red   = r_pix[AOB_NSTG-1].byp ? r_pix[AOB_NSTG-1].ch[0]
                                                   : w_div[AOB_NDIV].lq[0];
    assign o_res.out_green = r_pix[AOB_NSTG-1].byp ? r_pix[AOB_NSTG-1].ch[1]
                                                   : w_div[AOB_NDIV].lq[1];
    assign o_res.out_blue  = r_pix[AOB_NSTG-1].byp ? r_pix[AOB_NSTG-1].ch[2]
                                                   : w_div[AOB_NDIV].lq[2];
    assign o_res.out_alpha = r_pix[AOB_NSTG-1].byp ? r_pix[AOB_NSTG-1].alpha
                                                   : w_div[AOB_NDIV].alpha;

endmodule

/* hw/rtl/aob_check.sv */
module aob_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue,
    input logic [7:0] i_out_alpha,
    input logic       i_cfg_valid,
    input logic       i_cfg_ready
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_red) && $stable(i_out_green)
            && $stable(i_out_blue) && $stable(i_out_alpha))
        else $error("result changed while stalled");

    // input back-pressure only while a result is stalled at the output
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("configuration transaction refused");

endmodule

bind alpha_over_blend aob_check u_aob_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_red   (o_res.out_red),
    .i_out_green (o_res.out_green),
    .i_out_blue  (o_res.out_blue),
    .i_out_alpha (o_res.out_alpha),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);
